/* design/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 64;

    localparam int BLK_W  = 17;
    localparam int RES_W  = 16;
    localparam int LEN_W  = 7;
    localparam int LOC_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] DATA_BLOCKS_RST = 7'd50;
    localparam logic [RES_W-1:0] RESERVED_RST    = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_MARK  = 2'd1,
        OP_FREE  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_RUN = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Broadcast from the controller to every cell, stable during a scan
    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] n;
        logic [LOC_W-1:0] lo;
        logic [LOC_W-1:0] hi;
        logic             apply;
        logic             set_value;
    } cmd_t;

    // Scan wave handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] count;
        logic             found;
        logic [LOC_W-1:0] found_at;
        logic             is_free;
    } link_t;

endpackage

/* design/bitmap_block_allocator.sv */
`timescale 1ns / 1ps

// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_ready, operation, block_number,    | input
//         | run_length                                      |
// out     | out_valid, out_ready, start_block, is_free,     | output
//         | status                                          |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | input
//
// One transaction at a time. Mark and free go through CHECK and APPLY to DONE, where
// out_valid rises; rejected requests go from CHECK straight to DONE. Allocate and
// query send a wave down the row of NUM_BLOCKS cells, one cell per cycle, then go to
// DONE, via APPLY to update after a successful allocate. Reset gives data_blocks 50,
// reserved_blocks 2 and block 0 used. in_ready is low until the result is taken.

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [BLK_W-1:0]      block_number,
    input  logic [LEN_W-1:0]      run_length,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BLK_W-1:0]      start_block,
    output logic                  is_free,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] data_blocks_reg;
    logic [RES_W-1:0] reserved_reg;

    op_t              op_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] n_reg;
    logic [BLK_W-1:0] rel_reg;
    logic             below_reg;
    logic [LOC_W-1:0] lo_reg, lo_next;
    logic [LOC_W-1:0] hi_reg, hi_next;
    logic             set_reg, set_next;

    logic [BLK_W-1:0] start_reg, start_next;
    logic             free_reg, free_next;
    status_t          status_reg, status_next;

    logic [LEN_W-1:0] n_in;
    logic             rel_big;
    logic [LEN_W-1:0] room;
    logic             len_over;
    logic             inject;
    logic [LOC_W-1:0] found_end;

    cmd_t  cmd;
    link_t links [NUM_BLOCKS+1];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign cfg_ready = 1'b1;

    assign n_in = (32'(data_blocks_reg) < 32'(NUM_BLOCKS)) ? data_blocks_reg
                                                          : LEN_W'(NUM_BLOCKS);

    assign rel_big  = rel_reg >= BLK_W'(n_reg);
    assign room     = n_reg - rel_reg[LEN_W-1:0];
    assign len_over = len_reg > room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_blocks_reg <= DATA_BLOCKS_RST;
            reserved_reg    <= RESERVED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_DATA_BLOCKS)
                data_blocks_reg <= cfg_data[LEN_W-1:0];
            else if (cfg_index == CFG_RESERVED)
                reserved_reg <= cfg_data[RES_W-1:0];
        end
    end

    assign found_end = links[NUM_BLOCKS].found_at + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        set_next    = set_reg;
        start_next  = start_reg;
        free_next   = free_reg;
        status_next = status_reg;
        inject      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next  = '0;
                    free_next   = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                lo_next  = rel_reg[LOC_W-1:0];
                hi_next  = rel_reg[LOC_W-1:0] + LOC_W'(len_reg);
                set_next = (op_reg != OP_FREE);
                unique case (op_reg) inside
                    OP_ALLOC:
                    begin
                        if (len_reg == '0)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else if (len_reg > n_reg)
                        begin
                            status_next = ST_NO_RUN;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            inject     = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    OP_MARK, OP_FREE:
                    begin
                        if (len_reg == '0 || below_reg || rel_big || len_over)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_APPLY;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (below_reg || rel_big)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            inject     = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (links[NUM_BLOCKS].valid)
                begin
                    if (op_reg == OP_QUERY)
                    begin
                        free_next  = links[NUM_BLOCKS].is_free;
                        state_next = S_DONE;
                    end
                    else if (links[NUM_BLOCKS].found)
                    begin
                        lo_next    = found_end - LOC_W'(len_reg);
                        hi_next    = found_end;
                        set_next   = 1'b1;
                        start_next = BLK_W'(found_end - LOC_W'(len_reg))
                                     + BLK_W'(reserved_reg);
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        status_next = ST_NO_RUN;
                        state_next  = S_DONE;
                    end
                end
            end
            S_APPLY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op_t'(operation);
            len_reg   <= run_length;
            n_reg     <= n_in;
            rel_reg   <= block_number - BLK_W'(reserved_reg);
            below_reg <= block_number < BLK_W'(reserved_reg);
        end
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        set_reg    <= set_next;
        start_reg  <= start_next;
        free_reg   <= free_next;
        status_reg <= status_next;
    end

    assign cmd.op        = op_reg;
    assign cmd.len       = len_reg;
    assign cmd.n         = n_reg;
    assign cmd.lo        = (state_reg == S_CHECK) ? rel_reg[LOC_W-1:0] : lo_reg;
    assign cmd.hi        = hi_reg;
    assign cmd.apply     = (state_reg == S_APPLY);
    assign cmd.set_value = set_reg;

    // Head of the wave: empty run, nothing found
    assign links[0].valid    = inject;
    assign links[0].count    = '0;
    assign links[0].found    = 1'b0;
    assign links[0].found_at = '0;
    assign links[0].is_free  = 1'b0;

    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        bba_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    assign start_block = start_reg;
    assign is_free     = free_reg;
    assign status      = status_reg;

endmodule

/* design/bba_cell.sv */
`timescale 1ns / 1ps

module bba_cell
    import bba_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  link_t link_in,
    output link_t link_out
);

    logic  used_reg;
    logic  used_next;
    link_t link_reg;
    link_t link_next;
    logic  in_use;
    logic  in_span;

    assign in_use  = 32'(INDEX) < 32'(cmd.n);
    assign in_span = (32'(INDEX) >= 32'(cmd.lo)) && (32'(INDEX) < 32'(cmd.hi));

    always_comb
    begin
        link_next = link_in;
        if (link_in.valid && in_use)
        begin
            if (cmd.op == OP_ALLOC && !link_in.found)
            begin
                if (used_reg)
                begin
                    link_next.count = '0;
                end
                else
                begin
                    link_next.count = link_in.count + 1'b1;
                    if (link_next.count == cmd.len)
                    begin
                        link_next.found    = 1'b1;
                        link_next.found_at = LOC_W'(INDEX);
                    end
                end
            end
            else if (cmd.op == OP_QUERY && 32'(INDEX) == 32'(cmd.lo))
            begin
                link_next.is_free = ~used_reg;
            end
        end
    end

    assign used_next = (cmd.apply && in_span) ? cmd.set_value : used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= (INDEX == 0);
            link_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* tb/bitmap_block_allocator_test.sv */
`timescale 1ns / 1ps

module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam int NB          = NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic [BLK_W-1:0] start_block;
        logic             is_free;
        status_t          status;
    } reply_t;

    class alloc_scoreboard;
        bit [NB-1:0]    used_map;
        bit [LEN_W-1:0] data_blocks;
        bit [RES_W-1:0] reserved;
        reply_t         expected_replies[$];
        int             errors;
        int             op_count[4];
        int             status_count[3];
        int             reg_writes;

        function new();
            used_map    = '0;
            used_map[0] = 1'b1;
            data_blocks = DATA_BLOCKS_RST;
            reserved    = RESERVED_RST;
            errors      = 0;
            reg_writes  = 0;
        endfunction

        function int blocks_in_use();
            return (data_blocks < NB) ? int'(data_blocks) : NB;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == CFG_DATA_BLOCKS)
                data_blocks = data[LEN_W-1:0];
            else if (idx == CFG_RESERVED)
                reserved = data;
        endfunction

        // Works out the reply to one accepted request and updates the bitmap.
        function void note_request(logic [1:0] op_bits, logic [BLK_W-1:0] blk,
                                   logic [LEN_W-1:0] len);
            reply_t r;
            op_t    op;
            int     n, rel, first, count, i;
            op    = op_t'(op_bits);
            n     = blocks_in_use();
            first = -1;
            count = 0;
            r.start_block = '0;
            r.is_free     = 1'b0;
            r.status      = ST_OK;
            case (op) inside
                OP_ALLOC:
                begin
                    if (len == 0)
                        r.status = ST_RANGE;
                    else
                    begin
                        if (int'(len) <= n)
                        begin
                            for (i = 0; i < n && first < 0; i++)
                            begin
                                if (used_map[i])
                                    count = 0;
                                else
                                begin
                                    count++;
                                    if (count == int'(len))
                                        first = i + 1 - int'(len);
                                end
                            end
                        end
                        if (first < 0)
                            r.status = ST_NO_RUN;
                        else
                        begin
                            for (i = first; i < first + int'(len); i++)
                                used_map[i] = 1'b1;
                            r.start_block = BLK_W'(first + int'(reserved));
                        end
                    end
                end
                OP_MARK, OP_FREE:
                begin
                    if (len == 0 || blk < reserved)
                        r.status = ST_RANGE;
                    else
                    begin
                        rel = int'(blk) - int'(reserved);
                        if (rel >= n || int'(len) > n - rel)
                            r.status = ST_RANGE;   // no partial update
                        else
                            for (i = rel; i < rel + int'(len); i++)
                                used_map[i] = (op == OP_MARK);
                    end
                end
                default:
                begin
                    if (blk < reserved)
                        r.status = ST_RANGE;
                    else
                    begin
                        rel = int'(blk) - int'(reserved);
                        if (rel >= n)
                            r.status = ST_RANGE;
                        else
                            r.is_free = !used_map[rel];
                    end
                end
            endcase
            op_count[op]++;
            status_count[r.status]++;
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [BLK_W-1:0] start_block, logic is_free,
                                  logic [1:0] status);
            reply_t r;
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result: start_block %0d is_free %0d status %0d",
                       start_block, is_free, status);
                errors++;
                return;
            end
            r = expected_replies.pop_front();
            if (start_block !== r.start_block)
            begin
                $error("start_block: expected %0d, got %0d", r.start_block, start_block);
                errors++;
            end
            if (is_free !== r.is_free)
            begin
                $error("is_free: expected %0d, got %0d", r.is_free, is_free);
                errors++;
            end
            if (status !== r.status)
            begin
                $error("status: expected %0d, got %0d", r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            operation;
    logic [BLK_W-1:0]      block_number;
    logic [LEN_W-1:0]      run_length;
    logic                  out_valid;
    logic                  out_ready;
    logic [BLK_W-1:0]      start_block;
    logic                  is_free;
    logic [1:0]            status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alloc_scoreboard sb = new();
    bit              calm = 1'b0;
    int              cycles = 0;

    bitmap_block_allocator #(.NUM_BLOCKS(NB)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .block_number (block_number),
        .run_length   (run_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .start_block  (start_block),
        .is_free      (is_free),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid === 1'b1 && in_ready === 1'b1)
                sb.note_request(operation, block_number, run_length);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                sb.check_reply(start_block, is_free, status);
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_request(op_t op, int blk, int len);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        block_number <= BLK_W'(blk);
        run_length   <= LEN_W'(len);
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    task automatic take_results();
        int stall;
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every outstanding reply has been checked.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_random(int count);
        int  n, res, pick, blk, len, rel, k;
        op_t op;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            n    = sb.blocks_in_use();
            res  = sb.reserved;
            pick = $urandom_range(0, 99);
            op   = pick < 30 ? OP_ALLOC : pick < 45 ? OP_MARK :
                   pick < 75 ? OP_FREE : OP_QUERY;
            // mostly inside the bitmap, some just outside it, some anywhere
            pick = $urandom_range(0, 99);
            if (n > 0 && pick < 75)
                blk = res + $urandom_range(0, n - 1);
            else if (pick < 88)
                blk = $urandom_range(0, 1) ? res - 1 : res + n;
            else
                blk = $urandom_range(0, (1 << BLK_W) - 1);
            rel  = blk - res;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                len = $urandom_range(1, 8);
            else if (pick < 75 && rel >= 0 && rel < n)
                len = $urandom_range(1, n - rel);
            else if (pick < 90)
                len = $urandom_range(1, NB);
            else
                len = $urandom_range(0, (1 << LEN_W) - 1);
            send_request(op, blk, len);
        end
    endtask

    int db_set[8]  = '{64, 1, 0, 100, 13, 64, 5, 50};
    int res_set[8] = '{0, 65535, 100, 7, 1000, 65535, 65470, 2};

    initial
    begin
        int p;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= '0;
        block_number <= '0;
        run_length   <= '0;
        out_ready    <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            take_results();
        join_none

        // reset settings: 50 blocks, 2 reserved, block 0 used
        send_request(OP_QUERY, 2, 0);
        send_request(OP_QUERY, 3, 127);
        send_request(OP_QUERY, 1, 1);        // below reserved area
        send_request(OP_QUERY, 51, 1);       // last block in use
        send_request(OP_QUERY, 52, 1);       // one past the end
        send_request(OP_ALLOC, 0, 0);        // zero length
        send_request(OP_ALLOC, 0, 51);       // longer than blocks in use
        send_request(OP_ALLOC, 0, 127);
        send_request(OP_ALLOC, 131071, 49);  // takes every free block
        send_request(OP_ALLOC, 0, 1);        // nothing left
        send_request(OP_FREE, 2, 50);
        send_request(OP_ALLOC, 0, 50);
        send_request(OP_FREE, 3, 0);
        send_request(OP_MARK, 3, 0);
        send_request(OP_FREE, 10, 43);       // runs one past the end
        send_request(OP_FREE, 10, 42);
        send_request(OP_FREE, 1, 5);
        send_request(OP_MARK, 10, 1);
        send_request(OP_MARK, 10, 1);        // already used
        send_request(OP_FREE, 20, 1);
        send_request(OP_FREE, 20, 1);        // already free
        send_request(OP_MARK, 131071, 127);
        send_request(OP_QUERY, 131071, 0);
        send_request(OP_ALLOC, 0, 3);
        send_random(236);

        for (p = 0; p < 8; p++)
        begin
            drain();
            if ($urandom_range(0, 1))
            begin
                write_register(CFG_RESERVED, CFG_DATA_W'(res_set[p]));
                write_register(CFG_DATA_BLOCKS, {9'($urandom_range(0, 511)), 7'(db_set[p])});
            end
            else
            begin
                write_register(CFG_DATA_BLOCKS, {9'($urandom_range(0, 511)), 7'(db_set[p])});
                write_register(CFG_RESERVED, CFG_DATA_W'(res_set[p]));
            end
            send_random(db_set[p] == 0 ? 40 : 150);
        end

        drain();
        repeat (NB + 8) @(posedge clk);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());

        $display("Requests: %0d allocate, %0d mark, %0d free, %0d query; %0d register writes",
                 sb.op_count[OP_ALLOC], sb.op_count[OP_MARK], sb.op_count[OP_FREE],
                 sb.op_count[OP_QUERY], sb.reg_writes);
        $display("Replies: %0d ok, %0d no free run, %0d out of range",
                 sb.status_count[ST_OK], sb.status_count[ST_NO_RUN],
                 sb.status_count[ST_RANGE]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
design/bba_pkg.sv
design/bba_cell.sv
design/bitmap_block_allocator.sv
tb/bitmap_block_allocator_test.sv
